/* src/kmeans_clustering_engine_assert.svh */
// assertion macros shared by the kmeans clustering engine rtl
// depends on clk_i and rst_ni being present in the module that uses them
`ifndef KMEANS_CLUSTERING_ENGINE_ASSERT_SVH
`define KMEANS_CLUSTERING_ENGINE_ASSERT_SVH

// property must hold at every clock edge outside reset
`define KCE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("kce assertion failed");

// expression must never be true outside reset
`define KCE_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("kce forbidden condition seen");

`endif

/* src/kce_pkg.sv */
// shared constants, codes and controller/datapath interface structs
// no dependencies
package kce_pkg;

  localparam int MAX_POINTS   = 1024;
  localparam int MAX_DIMS     = 16;
  localparam int MAX_CLUSTERS = 16;

  localparam int PT_W    = 10;
  localparam int DIM_W   = 4;
  localparam int CL_W    = 4;
  localparam int COORD_W = 16;
  localparam int SUM_W   = 26;
  localparam int CNT_W   = 11;
  localparam int SQ_W    = 32;
  localparam int ACC_W   = 36;
  localparam int PASS_W  = 14;
  localparam int DIV_STEPS = 26;

  localparam logic [DIM_W-1:0] DIM_LAST = 4'd15;
  localparam logic [PASS_W-1:0] ITER_RESET = 14'd10000;
  localparam logic [COORD_W-1:0] UNASSIGNED_DATA = 16'hFFFF;

  // request codes
  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_SEED = 2'd1;
  localparam logic [1:0] REQ_RUN  = 2'd2;
  localparam logic [1:0] REQ_READ = 2'd3;

  // read selects
  localparam logic [1:0] SEL_ASSIGN   = 2'd0;
  localparam logic [1:0] SEL_CENTROID = 2'd1;
  localparam logic [1:0] SEL_SIZE     = 2'd2;
  localparam logic [1:0] SEL_NONE     = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_RUN = 2'd0;

  // config register indexes
  localparam logic [2:0] CFG_CLUSTERS = 3'd0;
  localparam logic [2:0] CFG_POINTS   = 3'd1;
  localparam logic [2:0] CFG_DIMS     = 3'd2;
  localparam logic [2:0] CFG_MODE     = 3'd3;
  localparam logic [2:0] CFG_LIMIT    = 3'd4;

  typedef struct packed {
    logic in_take;
    logic run_init;
    logic mod_load;
    logic mod_step;
    logic pick_mod;
    logic op_dist;
    logic op_copy;
    logic op_sum;
    logic acc_clr;
    logic near_upd;
    logic far_upd;
    logic first_q;
    logic first_i;
    logic best_clr;
    logic asg_upd;
    logic asg_rd;
    logic asg_commit;
    logic pass_start;
    logic pass_inc;
    logic set_conv;
    logic dead_set;
    logic sum_rd;
    logic div_start;
    logic ce_wr_div;
    logic out_load_run;
    logic out_load_rd;
    logic [PT_W-1:0]  pi;
    logic [CL_W-1:0]  ci;
    logic [DIM_W-1:0] m;
  } cmd_t;

  typedef struct packed {
    logic [CL_W-1:0]  k_last;
    logic [PT_W-1:0]  n_last;
    logic [DIM_W-1:0] d_last;
    logic             mode;
    logic [PT_W-1:0]  pick;
    logic [CL_W-1:0]  best_c;
    logic             mod_done;
    logic             pipe_busy;
    logic             div_done;
    logic             dead_sel;
    logic             count_zero;
    logic             changed;
    logic             limit_hit;
    logic             out_free;
  } status_t;

endpackage

/* src/kce_datapath.sv */
// datapath: config registers, point/centroid/assignment/sum memories,
// distance pipeline, divider, modulo unit and output register; uses kce_pkg
`include "kmeans_clustering_engine_assert.svh"
module kce_datapath
  import kce_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [13:0]        cfg_data_i,
  input  logic [1:0]         in_req_type_i,
  input  logic [PT_W-1:0]    in_point_index_i,
  input  logic [DIM_W-1:0]   in_dim_index_i,
  input  logic [CL_W-1:0]    in_cluster_index_i,
  input  logic [COORD_W-1:0] in_coord_value_i,
  input  logic [1:0]         in_read_select_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [1:0]         out_result_kind_o,
  output logic [COORD_W-1:0] out_result_data_o,
  output logic [PASS_W-1:0]  out_iterations_done_o,
  output logic               out_converged_o,
  output logic               out_cluster_dead_o,
  input  cmd_t               cmd_i,
  output status_t            st_o
);

  // config registers
  logic [4:0]        cc_q, dc_q;
  logic [10:0]       pc_q;
  logic              mode_q;
  logic [PASS_W-1:0] lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q   <= 5'd1;
      pc_q   <= 11'd1;
      dc_q   <= 5'd1;
      mode_q <= 1'b0;
      lim_q  <= ITER_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_CLUSTERS: cc_q   <= cfg_data_i[4:0];
        CFG_POINTS:   pc_q   <= cfg_data_i[10:0];
        CFG_DIMS:     dc_q   <= cfg_data_i[4:0];
        CFG_MODE:     mode_q <= cfg_data_i[0];
        CFG_LIMIT:    lim_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamped working values
  logic [4:0]        k_use, d_use;
  logic [10:0]       n_use;
  logic [PASS_W-1:0] lim_use;
  assign k_use = (cc_q == 5'd0) ? 5'd1 : (cc_q > 5'(MAX_CLUSTERS)) ? 5'(MAX_CLUSTERS) : cc_q;
  assign d_use = (dc_q == 5'd0) ? 5'd1 : (dc_q > 5'(MAX_DIMS)) ? 5'(MAX_DIMS) : dc_q;
  assign n_use = (pc_q == 11'd0) ? 11'd1 :
                 (pc_q > 11'(MAX_POINTS)) ? 11'(MAX_POINTS) : pc_q;
  assign lim_use = (lim_q == '0) ? 14'd1 : lim_q;

  logic in_load, in_seed, in_read;
  assign in_load = cmd_i.in_take && (in_req_type_i == REQ_LOAD);
  assign in_seed = cmd_i.in_take && (in_req_type_i == REQ_SEED);
  assign in_read = cmd_i.in_take && (in_req_type_i == REQ_READ);

  // pipeline stage tags
  logic             s1_dist_q, s1_copy_q, s1_sum_q, s2_q;
  logic [CL_W-1:0]  s1_ci_q;
  logic [DIM_W-1:0] s1_m_q;
  logic [SQ_W-1:0]  sq_q;

  // point memory
  logic [COORD_W-1:0] pt_mem [MAX_POINTS*MAX_DIMS];
  logic [COORD_W-1:0] pt_rdata_q;
  logic               pt_rd;
  assign pt_rd = cmd_i.op_dist || cmd_i.op_copy || cmd_i.op_sum;

  always_ff @(posedge clk_i) begin
    if (in_load) pt_mem[{in_point_index_i, in_dim_index_i}] <= in_coord_value_i;
    if (pt_rd) pt_rdata_q <= pt_mem[{cmd_i.pi, cmd_i.m}];
  end

  // divider registers
  logic               div_busy_q;
  logic [4:0]         div_cnt_q;
  logic [SUM_W-1:0]   dvd_q;
  logic [CNT_W-1:0]   rem_q, dvs_q;

  // centroid memory
  logic [COORD_W-1:0] ce_mem [MAX_CLUSTERS*MAX_DIMS];
  logic [COORD_W-1:0] ce_rdata_q;
  logic [CL_W+DIM_W-1:0] ce_raddr;
  assign ce_raddr = in_read ? {in_cluster_index_i, in_dim_index_i} : {cmd_i.ci, cmd_i.m};

  always_ff @(posedge clk_i) begin
    if (s1_copy_q) ce_mem[{s1_ci_q, s1_m_q}] <= pt_rdata_q;
    else if (cmd_i.ce_wr_div) ce_mem[{cmd_i.ci, cmd_i.m}] <= dvd_q[COORD_W-1:0];
    if (cmd_i.op_dist || in_read) ce_rdata_q <= ce_mem[ce_raddr];
  end

  // assignment memory, entries at or beyond last_n read as unassigned
  logic [4:0]      asg_mem [MAX_POINTS];
  logic [4:0]      asg_rdata_q;
  logic [CL_W-1:0] best_c_q;
  logic [PT_W-1:0] asg_raddr;
  assign asg_raddr = in_read ? in_point_index_i : cmd_i.pi;

  always_ff @(posedge clk_i) begin
    if (cmd_i.asg_commit) asg_mem[cmd_i.pi] <= {1'b0, best_c_q};
    if (cmd_i.asg_rd || in_read) asg_rdata_q <= asg_mem[asg_raddr];
  end

  // member counts and dead flags
  logic [CNT_W-1:0] cnt_q [MAX_CLUSTERS];
  logic [MAX_CLUSTERS-1:0] dead_q;

  // sum memory, a row counts as zero until its cluster has a member this pass
  logic [SUM_W-1:0] sum_mem [MAX_CLUSTERS*MAX_DIMS];
  logic [SUM_W-1:0] sum_rdata_q, sum_base, sum_wdata;
  assign sum_base  = (cnt_q[s1_ci_q] != '0) ? sum_rdata_q : '0;
  assign sum_wdata = sum_base + {{(SUM_W-COORD_W){1'b0}}, pt_rdata_q};

  always_ff @(posedge clk_i) begin
    if (s1_sum_q) sum_mem[{s1_ci_q, s1_m_q}] <= sum_wdata;
    if (cmd_i.op_sum || cmd_i.sum_rd) sum_rdata_q <= sum_mem[{cmd_i.ci, cmd_i.m}];
  end

  // squared difference of one coordinate pair
  logic [COORD_W-1:0] diff;
  assign diff = (pt_rdata_q > ce_rdata_q) ? (pt_rdata_q - ce_rdata_q)
                                          : (ce_rdata_q - pt_rdata_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_dist_q <= 1'b0;
      s1_copy_q <= 1'b0;
      s1_sum_q  <= 1'b0;
      s2_q      <= 1'b0;
    end else begin
      s1_dist_q <= cmd_i.op_dist;
      s1_copy_q <= cmd_i.op_copy;
      s1_sum_q  <= cmd_i.op_sum;
      s2_q      <= s1_dist_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_ci_q <= cmd_i.ci;
    s1_m_q  <= cmd_i.m;
    sq_q    <= diff * diff;
  end

  // distance accumulator and nearest/farthest trackers
  logic [ACC_W-1:0] acc_q, near_q, far_q, best_d_q, near_new;
  logic [PT_W-1:0]  pick_q;
  logic             found_q;
  assign near_new = (cmd_i.first_q || acc_q < near_q) ? acc_q : near_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_clr) acc_q <= '0;
    else if (s2_q) acc_q <= acc_q + {{(ACC_W-SQ_W){1'b0}}, sq_q};
    if (cmd_i.near_upd) near_q <= near_new;
    if (cmd_i.far_upd && (cmd_i.first_i || near_new > far_q)) far_q <= near_new;
    if (cmd_i.asg_upd && (!found_q || acc_q < best_d_q)) best_d_q <= acc_q;
  end

  // modulo unit for host seed indices
  logic [PT_W-1:0] mod_r_q;
  logic [PT_W-1:0] seed_q [MAX_CLUSTERS];

  always_ff @(posedge clk_i) begin
    if (cmd_i.mod_load) mod_r_q <= seed_q[cmd_i.ci];
    else if (cmd_i.mod_step) mod_r_q <= mod_r_q - n_use[PT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pick_q   <= '0;
      found_q  <= 1'b0;
      best_c_q <= '0;
    end else begin
      if (cmd_i.pick_mod) pick_q <= mod_r_q;
      else if (cmd_i.far_upd && (cmd_i.first_i || near_new > far_q)) pick_q <= cmd_i.pi;
      if (cmd_i.best_clr) begin
        found_q  <= 1'b0;
        best_c_q <= '0;
      end else if (cmd_i.asg_upd && (!found_q || acc_q < best_d_q)) begin
        found_q  <= 1'b1;
        best_c_q <= cmd_i.ci;
      end
    end
  end

  // seed index registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < MAX_CLUSTERS; c++) seed_q[c] <= '0;
    end else if (in_seed) begin
      seed_q[in_cluster_index_i] <= in_point_index_i;
    end
  end

  // restoring divider, one quotient bit per cycle
  logic [CNT_W:0] rem_sh, rem_sub;
  logic           div_ge;
  assign rem_sh  = {rem_q, dvd_q[SUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign div_ge  = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
      div_cnt_q  <= '0;
    end else if (cmd_i.div_start) begin
      div_busy_q <= 1'b1;
      div_cnt_q  <= 5'(DIV_STEPS);
    end else if (cmd_i.ce_wr_div) begin
      div_busy_q <= 1'b0;
    end else if (div_busy_q && div_cnt_q != '0) begin
      div_cnt_q <= div_cnt_q - 5'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dvd_q <= sum_rdata_q;
      rem_q <= '0;
      dvs_q <= cnt_q[cmd_i.ci];
    end else if (div_busy_q && div_cnt_q != '0) begin
      rem_q <= div_ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      dvd_q <= {dvd_q[SUM_W-2:0], div_ge};
    end
  end

  // run bookkeeping
  logic [PASS_W-1:0] pass_q;
  logic              conv_q, changed_q;
  logic [10:0]       last_n_q;
  logic [PASS_W:0]   pass_nxt;
  assign pass_nxt = {1'b0, pass_q} + 15'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_q    <= '0;
      conv_q    <= 1'b0;
      changed_q <= 1'b0;
      last_n_q  <= '0;
      dead_q    <= '0;
      for (int c = 0; c < MAX_CLUSTERS; c++) cnt_q[c] <= '0;
    end else begin
      if (cmd_i.run_init) begin
        pass_q   <= '0;
        conv_q   <= 1'b0;
        last_n_q <= n_use;
        dead_q   <= '0;
      end
      if (cmd_i.pass_inc) pass_q <= pass_nxt[PASS_W-1:0];
      if (cmd_i.set_conv) conv_q <= 1'b1;
      if (cmd_i.dead_set) dead_q[cmd_i.ci] <= (cnt_q[cmd_i.ci] == '0);
      if (cmd_i.pass_start) begin
        changed_q <= 1'b0;
        for (int c = 0; c < MAX_CLUSTERS; c++) cnt_q[c] <= '0;
      end else if (cmd_i.asg_commit) begin
        cnt_q[best_c_q] <= cnt_q[best_c_q] + 11'd1;
        if (pass_q == '0 || asg_rdata_q != {1'b0, best_c_q}) changed_q <= 1'b1;
      end
    end
  end

  // host read request fields
  logic [PT_W-1:0] rq_pi_q;
  logic [CL_W-1:0] rq_ci_q;
  logic [1:0]      rq_sel_q;

  always_ff @(posedge clk_i) begin
    if (in_read) begin
      rq_pi_q  <= in_point_index_i;
      rq_ci_q  <= in_cluster_index_i;
      rq_sel_q <= in_read_select_i;
    end
  end

  // read result formation
  logic [COORD_W-1:0] rd_data;
  logic               rd_dead;
  always_comb begin
    rd_data = '0;
    rd_dead = 1'b0;
    unique case (rq_sel_q)
      SEL_ASSIGN: begin
        if ({1'b0, rq_pi_q} >= last_n_q) begin
          rd_data = UNASSIGNED_DATA;
        end else begin
          rd_data = {12'd0, asg_rdata_q[CL_W-1:0]};
          rd_dead = dead_q[asg_rdata_q[CL_W-1:0]];
        end
      end
      SEL_CENTROID: begin
        rd_data = ce_rdata_q;
        rd_dead = dead_q[rq_ci_q];
      end
      SEL_SIZE: begin
        rd_data = {5'd0, cnt_q[rq_ci_q]};
        rd_dead = dead_q[rq_ci_q];
      end
      default: ;
    endcase
  end

  // output register
  logic out_valid_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.out_load_run || cmd_i.out_load_rd) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load_run || cmd_i.out_load_rd) begin
      out_iterations_done_o <= pass_q;
      out_converged_o       <= conv_q;
      out_result_kind_o     <= cmd_i.out_load_rd ? (rq_sel_q + 2'd1) : KIND_RUN;
      out_result_data_o     <= cmd_i.out_load_rd ? rd_data : '0;
      out_cluster_dead_o    <= cmd_i.out_load_rd ? rd_dead : 1'b0;
    end
  end
  assign out_valid_o = out_valid_q;

  // status back to the controller
  always_comb begin
    st_o.k_last     = 4'(k_use - 5'd1);
    st_o.n_last     = 10'(n_use - 11'd1);
    st_o.d_last     = 4'(d_use - 5'd1);
    st_o.mode       = mode_q;
    st_o.pick       = pick_q;
    st_o.best_c     = best_c_q;
    st_o.mod_done   = {1'b0, mod_r_q} < n_use;
    st_o.pipe_busy  = s1_dist_q || s1_copy_q || s1_sum_q || s2_q;
    st_o.div_done   = div_busy_q && (div_cnt_q == '0);
    st_o.dead_sel   = dead_q[cmd_i.ci];
    st_o.count_zero = (cnt_q[cmd_i.ci] == '0);
    st_o.changed    = changed_q;
    st_o.limit_hit  = pass_nxt >= {1'b0, lim_use};
    st_o.out_free   = !out_valid_q || out_ready_i;
  end

  // checks on internal sequencing
  `KCE_ASSERT(a_div_start_idle, cmd_i.div_start |-> !div_busy_q)
  `KCE_NEVER(a_ce_write_clash, s1_copy_q && cmd_i.ce_wr_div)
  `KCE_ASSERT(a_out_load_shows, (cmd_i.out_load_run || cmd_i.out_load_rd) |=> out_valid_q)
  `KCE_NEVER(a_commit_in_flight, cmd_i.asg_commit && (s1_sum_q || s2_q))

endmodule

/* src/kce_ctrl.sv */
// controller: sequences seeding, assignment passes and update passes
// drives cmd_t and reads status_t from kce_datapath; uses kce_pkg
module kce_ctrl
  import kce_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_req_type_i,
  input  logic [1:0] in_read_select_i,
  output logic       in_ready_o,
  input  status_t    st_i,
  output cmd_t       cmd_o
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_READ   = 5'd1;
  localparam logic [4:0] S_SEED   = 5'd2;
  localparam logic [4:0] S_MOD    = 5'd3;
  localparam logic [4:0] S_COPY   = 5'd4;
  localparam logic [4:0] S_COPY_W = 5'd5;
  localparam logic [4:0] S_FAR_D  = 5'd6;
  localparam logic [4:0] S_FAR_W  = 5'd7;
  localparam logic [4:0] S_ASG_J  = 5'd8;
  localparam logic [4:0] S_ASG_D  = 5'd9;
  localparam logic [4:0] S_ASG_W  = 5'd10;
  localparam logic [4:0] S_SUM    = 5'd11;
  localparam logic [4:0] S_SUM_W  = 5'd12;
  localparam logic [4:0] S_COMMIT = 5'd13;
  localparam logic [4:0] S_PASS   = 5'd14;
  localparam logic [4:0] S_UPD_J  = 5'd15;
  localparam logic [4:0] S_UPD_RD = 5'd16;
  localparam logic [4:0] S_UPD_DS = 5'd17;
  localparam logic [4:0] S_UPD_DV = 5'd18;
  localparam logic [4:0] S_DONE   = 5'd19;

  logic [4:0]       state_q, state_d;
  logic [PT_W-1:0]  i_q, i_d;
  logic [CL_W-1:0]  j_q, j_d, q_q, q_d;
  logic [DIM_W-1:0] m_q, m_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      q_q     <= '0;
      m_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      q_q     <= q_d;
      m_q     <= m_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  // next state and commands
  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    q_d     = q_q;
    m_d     = m_q;
    cmd_o    = '0;
    cmd_o.pi = i_q;
    cmd_o.ci = j_q;
    cmd_o.m  = m_q;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.in_take = in_valid_i;
        if (in_valid_i) begin
          if (in_req_type_i == REQ_RUN) begin
            cmd_o.run_init = 1'b1;
            j_d     = '0;
            state_d = S_SEED;
          end else if (in_req_type_i == REQ_READ && in_read_select_i != SEL_NONE) begin
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        if (st_i.out_free) begin
          cmd_o.out_load_rd = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_SEED: begin
        if (j_q == '0 || !st_i.mode) begin
          cmd_o.mod_load = 1'b1;
          state_d = S_MOD;
        end else begin
          i_d     = '0;
          q_d     = '0;
          m_d     = '0;
          state_d = S_FAR_D;
        end
      end
      S_MOD: begin
        if (st_i.mod_done) begin
          cmd_o.pick_mod = 1'b1;
          m_d     = '0;
          state_d = S_COPY;
        end else begin
          cmd_o.mod_step = 1'b1;
        end
      end
      // copy every coordinate slot of the picked point into centroid j
      S_COPY: begin
        cmd_o.pi      = st_i.pick;
        cmd_o.op_copy = 1'b1;
        if (m_q == DIM_LAST) state_d = S_COPY_W;
        else m_d = m_q + 4'd1;
      end
      S_COPY_W: begin
        if (!st_i.pipe_busy) begin
          if (j_q != st_i.k_last) begin
            j_d     = j_q + 4'd1;
            state_d = S_SEED;
          end else begin
            cmd_o.pass_start = 1'b1;
            i_d     = '0;
            j_d     = '0;
            state_d = S_ASG_J;
          end
        end
      end
      // farthest-point search: distance of point i to seed q
      S_FAR_D: begin
        cmd_o.ci      = q_q;
        cmd_o.op_dist = 1'b1;
        cmd_o.acc_clr = (m_q == '0);
        if (m_q == st_i.d_last) begin
          m_d     = '0;
          state_d = S_FAR_W;
        end else begin
          m_d = m_q + 4'd1;
        end
      end
      S_FAR_W: begin
        cmd_o.ci = q_q;
        if (!st_i.pipe_busy) begin
          cmd_o.near_upd = 1'b1;
          cmd_o.first_q  = (q_q == '0);
          if (q_q != j_q - 4'd1) begin
            q_d     = q_q + 4'd1;
            state_d = S_FAR_D;
          end else begin
            cmd_o.far_upd = 1'b1;
            cmd_o.first_i = (i_q == '0);
            if (i_q != st_i.n_last) begin
              i_d     = i_q + 10'd1;
              q_d     = '0;
              state_d = S_FAR_D;
            end else begin
              m_d     = '0;
              state_d = S_COPY;
            end
          end
        end
      end
      // assignment: walk live clusters for point i
      S_ASG_J: begin
        cmd_o.best_clr = (j_q == '0);
        m_d = '0;
        if (st_i.dead_sel) begin
          if (j_q != st_i.k_last) j_d = j_q + 4'd1;
          else state_d = S_SUM;
        end else begin
          state_d = S_ASG_D;
        end
      end
      S_ASG_D: begin
        cmd_o.op_dist = 1'b1;
        cmd_o.acc_clr = (m_q == '0);
        if (m_q == st_i.d_last) state_d = S_ASG_W;
        else m_d = m_q + 4'd1;
      end
      S_ASG_W: begin
        if (!st_i.pipe_busy) begin
          cmd_o.asg_upd = 1'b1;
          m_d = '0;
          if (j_q != st_i.k_last) begin
            j_d     = j_q + 4'd1;
            state_d = S_ASG_J;
          end else begin
            state_d = S_SUM;
          end
        end
      end
      // add point i into the sums of its cluster
      S_SUM: begin
        cmd_o.ci     = st_i.best_c;
        cmd_o.op_sum = 1'b1;
        cmd_o.asg_rd = (m_q == '0);
        if (m_q == st_i.d_last) state_d = S_SUM_W;
        else m_d = m_q + 4'd1;
      end
      S_SUM_W: begin
        if (!st_i.pipe_busy) state_d = S_COMMIT;
      end
      S_COMMIT: begin
        cmd_o.asg_commit = 1'b1;
        if (i_q != st_i.n_last) begin
          i_d     = i_q + 10'd1;
          j_d     = '0;
          state_d = S_ASG_J;
        end else begin
          state_d = S_PASS;
        end
      end
      S_PASS: begin
        cmd_o.pass_inc = 1'b1;
        if (!st_i.changed) begin
          cmd_o.set_conv = 1'b1;
          state_d = S_DONE;
        end else if (st_i.limit_hit) begin
          state_d = S_DONE;
        end else begin
          j_d     = '0;
          state_d = S_UPD_J;
        end
      end
      // update: mark empty clusters dead, divide sums of the others
      S_UPD_J: begin
        cmd_o.dead_set = 1'b1;
        m_d = '0;
        if (!st_i.count_zero) begin
          state_d = S_UPD_RD;
        end else if (j_q != st_i.k_last) begin
          j_d = j_q + 4'd1;
        end else begin
          cmd_o.pass_start = 1'b1;
          i_d     = '0;
          j_d     = '0;
          state_d = S_ASG_J;
        end
      end
      S_UPD_RD: begin
        cmd_o.sum_rd = 1'b1;
        state_d = S_UPD_DS;
      end
      S_UPD_DS: begin
        cmd_o.div_start = 1'b1;
        state_d = S_UPD_DV;
      end
      S_UPD_DV: begin
        if (st_i.div_done) begin
          cmd_o.ce_wr_div = 1'b1;
          if (m_q != st_i.d_last) begin
            m_d     = m_q + 4'd1;
            state_d = S_UPD_RD;
          end else if (j_q != st_i.k_last) begin
            j_d     = j_q + 4'd1;
            state_d = S_UPD_J;
          end else begin
            cmd_o.pass_start = 1'b1;
            i_d     = '0;
            j_d     = '0;
            state_d = S_ASG_J;
          end
        end
      end
      S_DONE: begin
        if (st_i.out_free) begin
          cmd_o.out_load_run = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

/* src/kmeans_clustering_engine.sv */
// top level of the k-means clustering engine: controller plus datapath
// depends on kce_pkg, kce_ctrl and kce_datapath
//
//   channel | direction | handshake               | payload
//   cfg     | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//   in      | in        | in_valid_i/in_ready_o   | req type, indices, coord, select
//   out     | out       | out_valid_o/out_ready_i | kind, data, passes, converged, dead
//
// a load or seed beat is taken in the idle state; a read waits in the read state until the output register is free.
// a run is sequenced by the controller: seeding by host index or by farthest point, then
// assignment passes that find the nearest live cluster of each point, and update passes
// that divide the cluster sums (one quotient bit per cycle).
// reset clears control state only; no clearing pass, points read as unassigned until run.
// the input channel is held while a read or run result waits for the output register.
module kmeans_clustering_engine
  import kce_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [13:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         in_req_type_i,
  input  logic [PT_W-1:0]    in_point_index_i,
  input  logic [DIM_W-1:0]   in_dim_index_i,
  input  logic [CL_W-1:0]    in_cluster_index_i,
  input  logic [COORD_W-1:0] in_coord_value_i,
  input  logic [1:0]         in_read_select_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         out_result_kind_o,
  output logic [COORD_W-1:0] out_result_data_o,
  output logic [PASS_W-1:0]  out_iterations_done_o,
  output logic               out_converged_o,
  output logic               out_cluster_dead_o
);

  cmd_t    cmd;
  status_t st;

  // config beats are always taken
  assign cfg_ready_o = 1'b1;

  kce_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_req_type_i    (in_req_type_i),
    .in_read_select_i (in_read_select_i),
    .in_ready_o       (in_ready_o),
    .st_i             (st),
    .cmd_o            (cmd)
  );

  kce_datapath u_datapath (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_valid_i           (cfg_valid_i),
    .cfg_index_i           (cfg_index_i),
    .cfg_data_i            (cfg_data_i),
    .in_req_type_i         (in_req_type_i),
    .in_point_index_i      (in_point_index_i),
    .in_dim_index_i        (in_dim_index_i),
    .in_cluster_index_i    (in_cluster_index_i),
    .in_coord_value_i      (in_coord_value_i),
    .in_read_select_i      (in_read_select_i),
    .out_ready_i           (out_ready_i),
    .out_valid_o           (out_valid_o),
    .out_result_kind_o     (out_result_kind_o),
    .out_result_data_o     (out_result_data_o),
    .out_iterations_done_o (out_iterations_done_o),
    .out_converged_o       (out_converged_o),
    .out_cluster_dead_o    (out_cluster_dead_o),
    .cmd_i                 (cmd),
    .st_o                  (st)
  );

endmodule

/* sim/kmeans_clustering_engine_tb.sv */
// self-checking testbench for kmeans_clustering_engine: queued driver, monitor, k-means predictor
// depends on kce_pkg and the engine rtl, nothing else
module kmeans_clustering_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kce_pkg::*;

  localparam logic [1:0] KIND_ASSIGN   = 2'd1;
  localparam logic [1:0] KIND_CENTROID = 2'd2;
  localparam logic [1:0] KIND_SIZE     = 2'd3;
  localparam logic [4:0] NO_CLUSTER    = 5'd31;
  localparam int LONG_HOLD = 400;

  typedef struct {
    logic [1:0]  req;
    logic [9:0]  pi;
    logic [3:0]  di;
    logic [3:0]  ci;
    logic [15:0] cv;
    logic [1:0]  sel;
  } req_beat_t;

  typedef struct {
    logic [1:0]  kind;
    logic [15:0] data;
    logic [13:0] iters;
    logic        conv;
    logic        dead;
  } res_beat_t;

  typedef struct {
    logic [2:0]  idx;
    logic [13:0] data;
  } cfg_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [13:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_req = '0;
  logic [9:0]  in_pi = '0;
  logic [3:0]  in_di = '0;
  logic [3:0]  in_ci = '0;
  logic [15:0] in_cv = '0;
  logic [1:0]  in_sel = '0;
  logic        out_valid;
  logic        out_rdy = 1'b0;
  logic [1:0]  out_kind;
  logic [15:0] out_data;
  logic [13:0] out_iters;
  logic        out_conv;
  logic        out_dead;

  req_beat_t pending_reqs[$];
  cfg_beat_t pending_cfg[$];
  res_beat_t expected_results[$];
  int        fails = 0;
  bit        quiet = 1'b0;
  bit        squeeze = 1'b0;

  // predictor state
  logic [15:0] pt_mem[MAX_POINTS*MAX_DIMS];
  bit          pt_ok[MAX_POINTS][MAX_DIMS];
  logic [15:0] ce_mem[MAX_CLUSTERS*MAX_DIMS];
  bit          ce_ok[MAX_CLUSTERS][MAX_DIMS];
  logic [4:0]  asg_mem[MAX_POINTS];
  bit          dead_mem[MAX_CLUSTERS];
  int unsigned sums[MAX_CLUSTERS*MAX_DIMS];
  int unsigned members[MAX_CLUSTERS];
  logic [9:0]  seeds[MAX_CLUSTERS];
  logic [13:0] passes;
  bit          conv_flag;
  logic [4:0]  reg_k;
  logic [10:0] reg_n;
  logic [4:0]  reg_d;
  logic        reg_mode;
  logic [13:0] reg_lim;

  kmeans_clustering_engine i_dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_valid_i           (cfg_valid),
    .cfg_ready_o           (cfg_ready),
    .cfg_index_i           (cfg_index),
    .cfg_data_i            (cfg_data),
    .in_valid_i            (in_valid),
    .in_ready_o            (in_ready),
    .in_req_type_i         (in_req),
    .in_point_index_i      (in_pi),
    .in_dim_index_i        (in_di),
    .in_cluster_index_i    (in_ci),
    .in_coord_value_i      (in_cv),
    .in_read_select_i      (in_sel),
    .out_valid_o           (out_valid),
    .out_ready_i           (out_rdy),
    .out_result_kind_o     (out_kind),
    .out_result_data_o     (out_data),
    .out_iterations_done_o (out_iters),
    .out_converged_o       (out_conv),
    .out_cluster_dead_o    (out_dead)
  );

  // clock
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // request driver with random idle bursts
  int in_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_ready)) begin
      if (in_valid && in_ready) void'(pending_reqs.pop_front());
      if (in_gap > 0) begin
        in_gap   <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0 && !quiet && $urandom_range(0, 15) == 0) begin
        in_gap   <= $urandom_range(0, 11);
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        in_valid <= 1'b1;
        in_req   <= pending_reqs[0].req;
        in_pi    <= pending_reqs[0].pi;
        in_di    <= pending_reqs[0].di;
        in_ci    <= pending_reqs[0].ci;
        in_cv    <= pending_reqs[0].cv;
        in_sel   <= pending_reqs[0].sel;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // register write driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_valid <= 1'b0;
    end else if (!(cfg_valid && !cfg_ready)) begin
      if (cfg_valid && cfg_ready) void'(pending_cfg.pop_front());
      if (pending_cfg.size() > 0) begin
        cfg_valid <= 1'b1;
        cfg_index <= pending_cfg[0].idx;
        cfg_data  <= pending_cfg[0].data;
      end else begin
        cfg_valid <= 1'b0;
      end
    end
  end

  // result monitor and receiver stalls
  int  hold_left = 0;
  bit  squeeze_done = 1'b0;
  always @(posedge clk_i or negedge rst_ni) begin
    res_beat_t want;
    if (!rst_ni) begin
      out_rdy <= 1'b0;
    end else begin
      if (out_valid && out_rdy) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result beat kind %0d data %0h", out_kind, out_data);
          fails++;
        end else begin
          want = expected_results.pop_front();
          if (out_kind !== want.kind) begin
            $error("result_kind expected %0d actual %0d", want.kind, out_kind);
            fails++;
          end
          if (out_data !== want.data) begin
            $error("result_data expected %0h actual %0h", want.data, out_data);
            fails++;
          end
          if (out_iters !== want.iters) begin
            $error("iterations_done expected %0d actual %0d", want.iters, out_iters);
            fails++;
          end
          if (out_conv !== want.conv) begin
            $error("converged expected %0d actual %0d", want.conv, out_conv);
            fails++;
          end
          if (out_dead !== want.dead) begin
            $error("cluster_dead expected %0d actual %0d", want.dead, out_dead);
            fails++;
          end
        end
      end
      if (squeeze && !squeeze_done) begin
        squeeze_done <= 1'b1;
        hold_left    <= LONG_HOLD;
        out_rdy      <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_rdy   <= (hold_left == 1);
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        hold_left <= $urandom_range(1, 12);
        out_rdy   <= 1'b0;
      end else begin
        out_rdy <= 1'b1;
      end
    end
  end

  function automatic int clamp_to(int v, int hi);
    if (v < 1) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic longint unsigned centroid_dist(int c, int p, int d);
    longint unsigned s;
    longint unsigned diff;
    s = 0;
    for (int m = 0; m < d; m++) begin
      diff = (ce_mem[c*MAX_DIMS+m] > pt_mem[p*MAX_DIMS+m]) ?
             ce_mem[c*MAX_DIMS+m] - pt_mem[p*MAX_DIMS+m] :
             pt_mem[p*MAX_DIMS+m] - ce_mem[c*MAX_DIMS+m];
      s += diff * diff;
    end
    return s;
  endfunction

  // full clustering run: seeding, then assignment and update passes
  function automatic void cluster_run();
    int k, n, d, lim, pick, changed, best_c;
    longint unsigned best, near, dd, best_d;
    bit found;
    k = clamp_to(reg_k, MAX_CLUSTERS);
    n = clamp_to(reg_n, MAX_POINTS);
    d = clamp_to(reg_d, MAX_DIMS);
    lim = clamp_to(reg_lim, 16383);
    for (int j = 0; j < k; j++) begin
      if (j == 0 || reg_mode == 1'b0) begin
        pick = int'(seeds[j]) % n;
      end else begin
        best = 0;
        pick = 0;
        for (int i = 0; i < n; i++) begin
          near = 0;
          for (int q = 0; q < j; q++) begin
            dd = centroid_dist(q, i, d);
            if (q == 0 || dd < near) near = dd;
          end
          if (i == 0 || near > best) begin
            best = near;
            pick = i;
          end
        end
      end
      for (int m = 0; m < MAX_DIMS; m++) begin
        ce_mem[j*MAX_DIMS+m] = pt_mem[pick*MAX_DIMS+m];
        ce_ok[j][m] = pt_ok[pick][m];
      end
    end
    for (int i = 0; i < MAX_POINTS; i++) asg_mem[i] = NO_CLUSTER;
    for (int j = 0; j < MAX_CLUSTERS; j++) dead_mem[j] = 1'b0;
    passes = '0;
    conv_flag = 1'b0;
    forever begin
      changed = 0;
      for (int j = 0; j < MAX_CLUSTERS; j++) members[j] = 0;
      for (int j = 0; j < MAX_CLUSTERS*MAX_DIMS; j++) sums[j] = 0;
      for (int i = 0; i < n; i++) begin
        best_c = 0;
        found = 1'b0;
        best_d = 0;
        for (int j = 0; j < k; j++) begin
          if (!dead_mem[j]) begin
            dd = centroid_dist(j, i, d);
            if (!found || dd < best_d) begin
              found = 1'b1;
              best_c = j;
              best_d = dd;
            end
          end
        end
        if (asg_mem[i] != best_c) changed++;
        asg_mem[i] = 5'(best_c);
        members[best_c]++;
        for (int m = 0; m < d; m++) sums[best_c*MAX_DIMS+m] += pt_mem[i*MAX_DIMS+m];
      end
      passes++;
      if (changed == 0) begin
        conv_flag = 1'b1;
        break;
      end
      if (passes >= lim) break;
      for (int j = 0; j < k; j++) begin
        dead_mem[j] = (members[j] == 0);
        if (!dead_mem[j]) begin
          for (int m = 0; m < d; m++) begin
            ce_mem[j*MAX_DIMS+m] = 16'(sums[j*MAX_DIMS+m] / members[j]);
            ce_ok[j][m] = 1'b1;
          end
        end
      end
    end
  endfunction

  // predicts the result of one request and queues the request, and its result for a run or a read
  function automatic void push_req(req_beat_t b);
    res_beat_t r;
    pending_reqs = {pending_reqs, b};
    r.kind = KIND_RUN;
    r.data = '0;
    r.dead = 1'b0;
    case (b.req)
      REQ_LOAD: begin
        pt_mem[b.pi*MAX_DIMS+b.di] = b.cv;
        pt_ok[b.pi][b.di] = 1'b1;
        return;
      end
      REQ_SEED: begin
        seeds[b.ci] = b.pi;
        return;
      end
      REQ_RUN: cluster_run();
      default: begin
        if (b.sel == SEL_NONE) return;
        if (b.sel == SEL_ASSIGN) begin
          r.kind = KIND_ASSIGN;
          if (asg_mem[b.pi] >= MAX_CLUSTERS) begin
            r.data = UNASSIGNED_DATA;
          end else begin
            r.data = {11'd0, asg_mem[b.pi]};
            r.dead = dead_mem[asg_mem[b.pi]];
          end
        end else if (b.sel == SEL_CENTROID) begin
          r.kind = KIND_CENTROID;
          r.data = ce_mem[b.ci*MAX_DIMS+b.di];
          r.dead = dead_mem[b.ci];
        end else begin
          r.kind = KIND_SIZE;
          r.data = 16'(members[b.ci]);
          r.dead = dead_mem[b.ci];
        end
      end
    endcase
    r.iters = passes;
    r.conv = conv_flag;
    expected_results = {expected_results, r};
  endfunction

  function automatic req_beat_t mk(logic [1:0] req, logic [9:0] pi, logic [3:0] di,
                                   logic [3:0] ci, logic [15:0] cv, logic [1:0] sel);
    req_beat_t b;
    b.req = req;
    b.pi = pi;
    b.di = di;
    b.ci = ci;
    b.cv = cv;
    b.sel = sel;
    return b;
  endfunction

  function automatic req_beat_t rand_beat(logic [1:0] req);
    return mk(req, 10'($urandom_range(0, 1023)), 4'($urandom_range(0, 15)),
              4'($urandom_range(0, 15)), 16'($urandom_range(0, 65535)),
              2'($urandom_range(0, 3)));
  endfunction

  // coordinates lumped around a few centers so runs take several passes
  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2, 3: return 16'($urandom_range(0, 3) * 16000 + $urandom_range(0, 400));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic void add_load(int p, int m);
    req_beat_t b;
    b = rand_beat(REQ_LOAD);
    b.pi = 10'(p);
    b.di = 4'(m);
    b.cv = rand_coord();
    push_req(b);
  endfunction

  // a run only after every coordinate in use has been loaded
  function automatic void add_run();
    for (int p = 0; p < clamp_to(reg_n, MAX_POINTS); p++)
      for (int m = 0; m < clamp_to(reg_d, MAX_DIMS); m++)
        if (!pt_ok[p][m]) add_load(p, m);
    push_req(rand_beat(REQ_RUN));
  endfunction

  // centroid reads only of coordinates that hold a value
  function automatic void add_read(logic [1:0] sel);
    req_beat_t b;
    b = rand_beat(REQ_READ);
    b.sel = sel;
    if ($urandom_range(0, 3) != 0)
      b.pi = 10'($urandom_range(0, clamp_to(reg_n, MAX_POINTS) - 1));
    if (sel == SEL_CENTROID && !ce_ok[b.ci][b.di]) begin
      if (ce_ok[b.ci][0]) b.di = '0;
      else b.sel = SEL_SIZE;
    end
    push_req(b);
  endfunction

  function automatic void add_random();
    int r;
    req_beat_t b;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      if ($urandom_range(0, 4) != 0)
        add_load($urandom_range(0, clamp_to(reg_n, MAX_POINTS) - 1),
                 $urandom_range(0, clamp_to(reg_d, MAX_DIMS) - 1));
      else
        add_load($urandom_range(0, 1023), $urandom_range(0, 15));
    end else if (r < 50) begin
      b = rand_beat(REQ_SEED);
      if ($urandom_range(0, 1) == 1)
        b.pi = 10'($urandom_range(0, clamp_to(reg_n, MAX_POINTS) - 1));
      push_req(b);
    end else if (r < 54) begin
      add_run();
    end else begin
      add_read(2'($urandom_range(0, 3)));
    end
  endfunction

  function automatic void set_reg(logic [2:0] idx, logic [13:0] val);
    cfg_beat_t c;
    c.idx = idx;
    c.data = val;
    pending_cfg = {pending_cfg, c};
    case (idx)
      CFG_CLUSTERS: reg_k = val[4:0];
      CFG_POINTS:   reg_n = val[10:0];
      CFG_DIMS:     reg_d = val[4:0];
      CFG_MODE:     reg_mode = val[0];
      default:      reg_lim = val;
    endcase
  endfunction

  // wait until all beats are out and every result is back, then let loads drain
  task automatic wait_idle();
    while (pending_reqs.size() > 0 || in_valid || expected_results.size() > 0 ||
           pending_cfg.size() > 0 || cfg_valid)
      @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic phase(int k, int n, int d, int mode, int lim, int count);
    set_reg(CFG_CLUSTERS, 14'(k));
    set_reg(CFG_POINTS, 14'(n));
    set_reg(CFG_DIMS, 14'(d));
    set_reg(CFG_MODE, 14'(mode));
    set_reg(CFG_LIMIT, 14'(lim));
    wait_idle();
    add_run();
    for (int i = 0; i < count; i++) add_random();
    add_run();
    repeat (6) add_read(2'($urandom_range(0, 2)));
    wait_idle();
  endtask

  // stimulus
  initial begin
    int lim;
    reg_k = 5'd1;
    reg_n = 11'd1;
    reg_d = 5'd1;
    reg_mode = 1'b0;
    reg_lim = ITER_RESET;
    for (int i = 0; i < MAX_POINTS; i++) begin
      asg_mem[i] = NO_CLUSTER;
      for (int m = 0; m < MAX_DIMS; m++) pt_ok[i][m] = 1'b0;
    end
    for (int j = 0; j < MAX_CLUSTERS; j++) begin
      dead_mem[j] = 1'b0;
      members[j] = 0;
      seeds[j] = '0;
      for (int m = 0; m < MAX_DIMS; m++) ce_ok[j][m] = 1'b0;
    end
    passes = '0;
    conv_flag = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed beats under the reset settings
    push_req(mk(REQ_READ, 10'd0, 4'd0, 4'd0, 16'd0, SEL_ASSIGN));
    push_req(mk(REQ_READ, 10'd1023, 4'd15, 4'd15, 16'hFFFF, SEL_SIZE));
    push_req(mk(REQ_READ, 10'd5, 4'd3, 4'd2, 16'd7, SEL_NONE));
    push_req(mk(REQ_LOAD, 10'd0, 4'd0, 4'd0, 16'hFFFF, SEL_NONE));
    push_req(mk(REQ_LOAD, 10'd1023, 4'd15, 4'd15, 16'h0000, SEL_ASSIGN));
    push_req(mk(REQ_LOAD, 10'd0, 4'd15, 4'd9, 16'h5A5A, SEL_CENTROID));
    push_req(mk(REQ_RUN, 10'd1023, 4'd15, 4'd15, 16'hFFFF, SEL_NONE));
    push_req(mk(REQ_READ, 10'd0, 4'd0, 4'd0, 16'd0, SEL_ASSIGN));
    push_req(mk(REQ_READ, 10'd1, 4'd0, 4'd0, 16'd0, SEL_ASSIGN));
    push_req(mk(REQ_READ, 10'd0, 4'd0, 4'd0, 16'd0, SEL_CENTROID));
    push_req(mk(REQ_READ, 10'd0, 4'd15, 4'd0, 16'd0, SEL_CENTROID));
    push_req(mk(REQ_READ, 10'd0, 4'd0, 4'd0, 16'd0, SEL_SIZE));
    push_req(mk(REQ_READ, 10'd0, 4'd0, 4'd15, 16'd0, SEL_SIZE));
    push_req(mk(REQ_SEED, 10'd1023, 4'd15, 4'd15, 16'hFFFF, SEL_NONE));
    push_req(mk(REQ_SEED, 10'd1023, 4'd0, 4'd0, 16'd0, SEL_NONE));
    push_req(mk(REQ_LOAD, 10'd0, 4'd0, 4'd0, 16'd0, SEL_NONE));
    push_req(mk(REQ_RUN, 10'd0, 4'd0, 4'd0, 16'd0, SEL_NONE));
    push_req(mk(REQ_READ, 10'd0, 4'd0, 4'd0, 16'd0, SEL_CENTROID));
    push_req(mk(REQ_READ, 10'd0, 4'd0, 4'd0, 16'd0, SEL_ASSIGN));
    push_req(mk(REQ_READ, 10'd1023, 4'd0, 4'd0, 16'd0, SEL_ASSIGN));
    wait_idle();

    // every register at a clamped extreme: all points, one pass
    phase(0, 2047, 0, 0, 0, 20);
    // widest clusters and dimensions with farthest seeding, then a stalled read burst
    phase(16, 8, 16, 1, 16383, 10);
    squeeze = 1'b1;
    repeat (20) add_read(2'($urandom_range(0, 2)));
    wait_idle();
    // more clusters than points, so clusters die
    phase(31, 5, 31, 1, 3, 10);
    phase(16, 3, 2, 0, 16383, 10);

    // random settings
    for (int ph = 0; ph < 3; ph++) begin
      case ($urandom_range(0, 4))
        0: lim = 1;
        1: lim = 2;
        2: lim = 16383;
        default: lim = $urandom_range(1, 40);
      endcase
      if (ph == 2) quiet = 1'b1;
      phase($urandom_range(1, 6), $urandom_range(1, 24), $urandom_range(1, 4),
            $urandom_range(0, 1), lim, 12);
    end
    repeat (50) @(negedge clk_i);

    if (fails == 0) begin
      $display("kmeans_clustering_engine_tb passed");
    end else begin
      $display("kmeans_clustering_engine_tb failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #200000000;
    $display("kmeans_clustering_engine_tb failed");
    $finish;
  end

endmodule
